FILE: hdl/spl_pkg.sv
// Shared types and constants of the sector point locator.
`timescale 1ns / 1ps
package spl_pkg;
  localparam int COORD_BITS      = 24;
  localparam int LINK_BITS       = 7;
  localparam int SECF_BITS       = 6;
  localparam int WALLF_BITS      = 4;
  localparam int CNTF_BITS       = 5;
  localparam int TOTAL_BITS      = 7;
  localparam int IN_TDATA_BITS   = 168;
  localparam int OUT_TDATA_BITS  = 8;
  localparam int MAX_SECTORS_DEF = 64;
  localparam int MAX_WALLS_DEF   = 16;

  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_LOCATE = 1'b1;

  typedef struct packed {
    logic signed [LINK_BITS-1:0]  link;
    logic signed [COORD_BITS-1:0] y_end;
    logic signed [COORD_BITS-1:0] x_end;
    logic signed [COORD_BITS-1:0] y_start;
    logic signed [COORD_BITS-1:0] x_start;
  } wall_t;

  typedef struct packed {
    logic busy;
    logic hit_v;
    logic hit;
  } cross_st_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_CNT, ST_WALL, ST_DRAIN, ST_NRD, ST_NWAIT, ST_LIN, ST_FIN
  } state_t;

  typedef enum logic [1:0] {PH_CUR, PH_NBR, PH_LIN} phase_t;
endpackage

FILE: hdl/spl_mem.sv
// Wall table and per-sector wall count memories.
`timescale 1ns / 1ps
module spl_mem #(
  parameter int MAX_SECTORS = spl_pkg::MAX_SECTORS_DEF,
  parameter int MAX_WALLS   = spl_pkg::MAX_WALLS_DEF,
  localparam int AW = $clog2(MAX_SECTORS * MAX_WALLS),
  localparam int SW = (MAX_SECTORS > 1) ? $clog2(MAX_SECTORS) : 1,
  localparam int CW = $clog2(MAX_WALLS + 1)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  we,
  input  logic [AW-1:0]         waddr,
  input  spl_pkg::wall_t        wdata,
  input  logic                  re,
  input  logic [AW-1:0]         raddr,
  output spl_pkg::wall_t        rdata,
  input  logic                  cwe,
  input  logic [SW-1:0]         caddr_w,
  input  logic [CW-1:0]         cdata,
  input  logic                  cre,
  input  logic [SW-1:0]         caddr_r,
  output logic [CW-1:0]         cnt_q
);
  spl_pkg::wall_t wall_ram [MAX_SECTORS*MAX_WALLS];
  logic [CW-1:0]  cnt_ram [MAX_SECTORS];
  logic [MAX_SECTORS-1:0] cvalid_r;
  spl_pkg::wall_t rdata_r;
  logic [CW-1:0]  cnt_r;
  logic           cv_r;

  always_ff @(posedge clk) begin
    if (we) wall_ram[waddr] <= wdata;
    if (re) rdata_r <= wall_ram[raddr];
    if (cwe) cnt_ram[caddr_w] <= cdata;
    if (cre) cnt_r <= cnt_ram[caddr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cvalid_r <= '0;
      cv_r     <= 1'b0;
    end else begin
      if (cwe) cvalid_r[caddr_w] <= 1'b1;
      if (cre) cv_r <= cvalid_r[caddr_r];
    end
  end

  assign rdata = rdata_r;
  assign cnt_q = cv_r ? cnt_r : '0;
endmodule

FILE: hdl/spl_cross.sv
// Three-stage crossing test of one wall against an upward ray.
`timescale 1ns / 1ps
module spl_cross (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  v,
  input  spl_pkg::wall_t                        wl,
  input  logic signed [spl_pkg::COORD_BITS-1:0] pos_x,
  input  logic signed [spl_pkg::COORD_BITS-1:0] pos_y,
  output spl_pkg::cross_st_t                    st
);
  localparam int DW = spl_pkg::COORD_BITS + 1;
  localparam int PW = 2 * DW;

  logic signed [DW-1:0] ax_r, ay_r, bx_r, by_r;
  logic signed [DW-1:0] ax2_r, bx2_r;
  logic signed [PW-1:0] p1_r, p2_r;
  logic signed [PW:0]   diff;
  logic signed [DW:0]   d, n2;
  logic                 v1_r, v2_r, v3_r, hit_r, hit_nxt;
  logic                 sd_pos, sd_neg, ok1, ok2, ok3;

  always_ff @(posedge clk) begin
    ax_r  <= DW'(pos_x) - DW'(wl.x_start);
    ay_r  <= DW'(pos_y) - DW'(wl.y_start);
    bx_r  <= DW'(wl.x_end) - DW'(wl.x_start);
    by_r  <= DW'(wl.y_end) - DW'(wl.y_start);
    p1_r  <= bx_r * ay_r;
    p2_r  <= by_r * ax_r;
    ax2_r <= ax_r;
    bx2_r <= bx_r;
    hit_r <= hit_nxt;
  end

  always_comb begin
    diff   = (PW+1)'(p1_r) - (PW+1)'(p2_r);
    d      = -((DW+1)'(bx2_r));
    n2     = -((DW+1)'(ax2_r));
    sd_pos = d > 0;
    sd_neg = d < 0;
    ok1    = sd_pos ? (diff >= 0) : (diff <= 0);
    ok2    = sd_pos ? (n2 >= 0) : (n2 <= 0);
    ok3    = sd_pos ? (n2 <= d) : (n2 >= d);
    hit_nxt = (sd_pos || sd_neg) && ok1 && ok2 && ok3;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= v;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  assign st.busy  = v1_r | v2_r | v3_r;
  assign st.hit_v = v3_r;
  assign st.hit   = hit_r;
endmodule

FILE: hdl/spl_ctrl.sv
// Request handshake, table loads and the search sequencer.
`timescale 1ns / 1ps
module spl_ctrl #(
  parameter int MAX_SECTORS = spl_pkg::MAX_SECTORS_DEF,
  parameter int MAX_WALLS   = spl_pkg::MAX_WALLS_DEF,
  localparam int AW = $clog2(MAX_SECTORS * MAX_WALLS),
  localparam int SW = (MAX_SECTORS > 1) ? $clog2(MAX_SECTORS) : 1,
  localparam int CW = $clog2(MAX_WALLS + 1),
  localparam int TW = ($clog2(MAX_SECTORS + 1) > 7) ? $clog2(MAX_SECTORS + 1) : 7
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  cmd,
  input  logic [spl_pkg::SECF_BITS-1:0]         sector,
  input  logic [spl_pkg::WALLF_BITS-1:0]        wall,
  input  logic [spl_pkg::CNTF_BITS-1:0]         wall_count,
  input  logic signed [spl_pkg::COORD_BITS-1:0] pos_x,
  input  logic signed [spl_pkg::COORD_BITS-1:0] pos_y,
  input  logic                                  cfg_wr_en,
  input  logic [spl_pkg::TOTAL_BITS-1:0]        cfg_wr_data,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [spl_pkg::OUT_TDATA_BITS-1:0]    out_data,
  output logic                                  we,
  output logic [AW-1:0]                         waddr,
  output logic                                  re,
  output logic [AW-1:0]                         raddr,
  input  spl_pkg::wall_t                        rdata,
  output logic                                  cwe,
  output logic [SW-1:0]                         caddr_w,
  output logic [CW-1:0]                         cdata,
  output logic                                  cre,
  output logic [SW-1:0]                         caddr_r,
  input  logic [CW-1:0]                         cnt_q,
  output logic                                  rdv,
  output logic signed [spl_pkg::COORD_BITS-1:0] qx,
  output logic signed [spl_pkg::COORD_BITS-1:0] qy,
  input  spl_pkg::cross_st_t                    cst
);
  spl_pkg::state_t state_r, state_nxt;
  spl_pkg::phase_t phase_r, phase_nxt;
  logic [TW-1:0] tsec_r, tsec_nxt, cur_r, cur_nxt, loc_r, loc_nxt, lim;
  logic [CW-1:0] wi_r, wi_nxt, nbi_r, nbi_nxt, curn_r, curn_nxt, n;
  logic          tin_r, tin_nxt, par_r, par_nxt, found_r, found_nxt, rdv_r, rdv_nxt;
  logic [spl_pkg::TOTAL_BITS-1:0] total_r;
  logic signed [spl_pkg::COORD_BITS-1:0] qx_r, qy_r;
  logic          out_valid_r, out_valid_nxt;
  logic [spl_pkg::OUT_TDATA_BITS-1:0] out_data_r, out_data_nxt;
  logic          acc, link_ok, tin;

  assign acc      = in_valid && in_ready;
  assign in_ready = (state_r == spl_pkg::ST_IDLE);
  assign n        = tin_r ? cnt_q : '0;
  assign lim      = (32'(total_r) > MAX_SECTORS) ? TW'(MAX_SECTORS) : TW'(total_r);
  assign link_ok  = !rdata.link[spl_pkg::LINK_BITS-1] &&
                    (32'(rdata.link[spl_pkg::LINK_BITS-2:0]) < MAX_SECTORS);
  assign tin      = 32'(tsec_r) < MAX_SECTORS;

  // table writes on load requests
  always_comb begin
    we      = acc && (cmd == spl_pkg::CMD_LOAD) && (32'(sector) < MAX_SECTORS) &&
              (32'(wall) < MAX_WALLS);
    waddr   = AW'(32'(sector) * MAX_WALLS + 32'(wall));
    cwe     = we;
    caddr_w = SW'(32'(sector));
    cdata   = (32'(wall_count) > MAX_WALLS) ? CW'(MAX_WALLS) : CW'(wall_count);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      spl_pkg::ST_IDLE:  if (acc && cmd == spl_pkg::CMD_LOCATE) state_nxt = spl_pkg::ST_CNT;
      spl_pkg::ST_CNT:   state_nxt = spl_pkg::ST_WALL;
      spl_pkg::ST_WALL:  if (wi_r >= n) state_nxt = spl_pkg::ST_DRAIN;
      spl_pkg::ST_DRAIN: begin
        if (!rdv_r && !cst.busy) begin
          priority if (par_r) state_nxt = spl_pkg::ST_FIN;
          else if (phase_r == spl_pkg::PH_LIN) state_nxt = spl_pkg::ST_LIN;
          else state_nxt = spl_pkg::ST_NRD;
        end
      end
      spl_pkg::ST_NRD:   state_nxt = (nbi_r < curn_r) ? spl_pkg::ST_NWAIT : spl_pkg::ST_LIN;
      spl_pkg::ST_NWAIT: state_nxt = link_ok ? spl_pkg::ST_CNT : spl_pkg::ST_NRD;
      spl_pkg::ST_LIN:   state_nxt = (tsec_r < lim) ? spl_pkg::ST_CNT : spl_pkg::ST_FIN;
      spl_pkg::ST_FIN:   if (!out_valid_r || out_ready) state_nxt = spl_pkg::ST_IDLE;
      default:           state_nxt = spl_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    phase_nxt = phase_r;
    tsec_nxt  = tsec_r;
    cur_nxt   = cur_r;
    loc_nxt   = loc_r;
    wi_nxt    = wi_r;
    nbi_nxt   = nbi_r;
    curn_nxt  = curn_r;
    tin_nxt   = tin_r;
    found_nxt = found_r;
    rdv_nxt   = 1'b0;
    par_nxt   = par_r ^ (cst.hit_v & cst.hit);
    re        = 1'b0;
    raddr     = AW'(32'(tsec_r) * MAX_WALLS + 32'(wi_r));
    cre       = 1'b0;
    caddr_r   = tsec_r[SW-1:0];
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    unique case (state_r)
      spl_pkg::ST_IDLE: begin
        if (acc && cmd == spl_pkg::CMD_LOCATE) begin
          cur_nxt   = TW'(sector);
          tsec_nxt  = TW'(sector);
          loc_nxt   = TW'(sector);
          phase_nxt = spl_pkg::PH_CUR;
          found_nxt = 1'b0;
          nbi_nxt   = '0;
        end
      end
      spl_pkg::ST_CNT: begin
        cre     = tin;
        tin_nxt = tin;
        wi_nxt  = '0;
        par_nxt = 1'b0;
      end
      spl_pkg::ST_WALL: begin
        if (phase_r == spl_pkg::PH_CUR) curn_nxt = n;
        if (wi_r < n) begin
          re      = 1'b1;
          rdv_nxt = 1'b1;
          wi_nxt  = wi_r + 1'b1;
        end
      end
      spl_pkg::ST_DRAIN: begin
        if (!rdv_r && !cst.busy) begin
          if (par_r) begin
            found_nxt = 1'b1;
            loc_nxt   = tsec_r;
          end else if (phase_r == spl_pkg::PH_LIN) begin
            tsec_nxt = tsec_r + 1'b1;
          end else if (phase_r == spl_pkg::PH_NBR) begin
            nbi_nxt = nbi_r + 1'b1;
          end
        end
      end
      spl_pkg::ST_NRD: begin
        raddr = AW'(32'(cur_r) * MAX_WALLS + 32'(nbi_r));
        if (nbi_r < curn_r) begin
          re = 1'b1;
        end else begin
          phase_nxt = spl_pkg::PH_LIN;
          tsec_nxt  = '0;
        end
      end
      spl_pkg::ST_NWAIT: begin
        if (link_ok) begin
          tsec_nxt  = TW'(rdata.link[spl_pkg::LINK_BITS-2:0]);
          phase_nxt = spl_pkg::PH_NBR;
        end else begin
          nbi_nxt = nbi_r + 1'b1;
        end
      end
      spl_pkg::ST_LIN: ;
      spl_pkg::ST_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {loc_r != cur_r, found_r, loc_r[spl_pkg::SECF_BITS-1:0]};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= spl_pkg::ST_IDLE;
      phase_r     <= spl_pkg::PH_CUR;
      rdv_r       <= 1'b0;
      out_valid_r <= 1'b0;
      total_r     <= '0;
      found_r     <= 1'b0;
      par_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      rdv_r       <= rdv_nxt;
      out_valid_r <= out_valid_nxt;
      found_r     <= found_nxt;
      par_r       <= par_nxt;
      if (cfg_wr_en) total_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    tsec_r     <= tsec_nxt;
    cur_r      <= cur_nxt;
    loc_r      <= loc_nxt;
    wi_r       <= wi_nxt;
    nbi_r      <= nbi_nxt;
    curn_r     <= curn_nxt;
    tin_r      <= tin_nxt;
    out_data_r <= out_data_nxt;
    if (acc) begin
      qx_r <= pos_x;
      qy_r <= pos_y;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign rdv       = rdv_r;
  assign qx        = qx_r;
  assign qy        = qy_r;

`ifndef SYNTH
  a_rdv_src: assert property (@(posedge clk) disable iff (!rst_n)
    rdv_r |-> $past(state_r) == spl_pkg::ST_WALL)
    else $error("wall read valid without a wall scan");
  a_found_rng: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == spl_pkg::ST_FIN && found_r) |-> 32'(loc_r) < MAX_SECTORS)
    else $error("located sector out of range");
  a_moved: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r[spl_pkg::SECF_BITS+1]) |-> out_data_r[spl_pkg::SECF_BITS])
    else $error("moved without found");
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == spl_pkg::ST_CNT) |-> (!rdv_r && !cst.busy))
    else $error("crossing pipeline busy at sector start");
`endif
endmodule

FILE: hdl/sector_point_locator_top.sv
// Top level of the sector point locator.
`timescale 1ns / 1ps
// Holds up to MAX_SECTORS polygonal sectors of up to MAX_WALLS walls and
// finds the sector holding a position by crossing-number parity. A load
// request gives no result. A query tests the current sector, then its
// linked neighbours in wall order, then sectors 0 to sector_total-1 (at
// most the first MAX_SECTORS). The single read port of the wall memory
// feeds one wall per cycle into a three-stage crossing pipeline. One query
// is in work at a time; a result may wait in the output register while the
// next request is taken.
module sector_point_locator_top #(
  parameter int MAX_SECTORS = spl_pkg::MAX_SECTORS_DEF,
  parameter int MAX_WALLS   = spl_pkg::MAX_WALLS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // sector, wall, x_start, y_start, x_end, y_end, link, wall_count, pos_x, pos_y
  input  logic [spl_pkg::IN_TDATA_BITS-1:0]     in_tdata,
  // command
  input  logic [0:0]                            in_tuser,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // located_sector, found, moved
  output logic [spl_pkg::OUT_TDATA_BITS-1:0]    out_tdata,
  input  logic                                  cfg_wr_en,
  input  logic [spl_pkg::TOTAL_BITS-1:0]        cfg_wr_data
);
  localparam int AW = $clog2(MAX_SECTORS * MAX_WALLS);
  localparam int SW = (MAX_SECTORS > 1) ? $clog2(MAX_SECTORS) : 1;
  localparam int CW = $clog2(MAX_WALLS + 1);

  spl_pkg::wall_t     wall_in, rdata;
  spl_pkg::cross_st_t cst;
  logic               we, re, cwe, cre, rdv;
  logic [AW-1:0]      waddr, raddr;
  logic [SW-1:0]      caddr_w, caddr_r;
  logic [CW-1:0]      cdata, cnt_q;
  logic signed [spl_pkg::COORD_BITS-1:0] qx, qy;

  assign wall_in.x_start = in_tdata[33:10];
  assign wall_in.y_start = in_tdata[57:34];
  assign wall_in.x_end   = in_tdata[81:58];
  assign wall_in.y_end   = in_tdata[105:82];
  assign wall_in.link    = in_tdata[112:106];

  spl_ctrl #(.MAX_SECTORS(MAX_SECTORS), .MAX_WALLS(MAX_WALLS)) u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_tvalid), .in_ready(in_tready), .cmd(in_tuser[0]),
    .sector(in_tdata[5:0]), .wall(in_tdata[9:6]),
    .wall_count(in_tdata[117:113]), .pos_x(in_tdata[141:118]),
    .pos_y(in_tdata[165:142]),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .out_valid(out_tvalid), .out_ready(out_tready), .out_data(out_tdata),
    .we(we), .waddr(waddr), .re(re), .raddr(raddr), .rdata(rdata),
    .cwe(cwe), .caddr_w(caddr_w), .cdata(cdata), .cre(cre), .caddr_r(caddr_r),
    .cnt_q(cnt_q), .rdv(rdv), .qx(qx), .qy(qy), .cst(cst)
  );

  spl_mem #(.MAX_SECTORS(MAX_SECTORS), .MAX_WALLS(MAX_WALLS)) u_mem (
    .clk(clk), .rst_n(rst_n),
    .we(we), .waddr(waddr), .wdata(wall_in), .re(re), .raddr(raddr), .rdata(rdata),
    .cwe(cwe), .caddr_w(caddr_w), .cdata(cdata), .cre(cre), .caddr_r(caddr_r),
    .cnt_q(cnt_q)
  );

  spl_cross u_cross (
    .clk(clk), .rst_n(rst_n), .v(rdv), .wl(rdata), .pos_x(qx), .pos_y(qy), .st(cst)
  );
endmodule

FILE: tb/testbench.sv
// Self-checking testbench for the sector point locator: grid maps, queries, config phases.
`timescale 1ns / 1ps
module testbench;
  localparam int COORD_BITS     = spl_pkg::COORD_BITS;
  localparam int LINK_BITS      = spl_pkg::LINK_BITS;
  localparam int SECF_BITS      = spl_pkg::SECF_BITS;
  localparam int WALLF_BITS     = spl_pkg::WALLF_BITS;
  localparam int CNTF_BITS      = spl_pkg::CNTF_BITS;
  localparam int TOTAL_BITS     = spl_pkg::TOTAL_BITS;
  localparam int IN_TDATA_BITS  = spl_pkg::IN_TDATA_BITS;
  localparam int OUT_TDATA_BITS = spl_pkg::OUT_TDATA_BITS;

  localparam int CELL = 3072;
  localparam int RUN_LIMIT = 5000000;
  localparam int LONG_HOLD = 3000;

  typedef struct {
    logic                         cmd;
    logic [SECF_BITS-1:0]         sector;
    logic [WALLF_BITS-1:0]        wall;
    logic signed [COORD_BITS-1:0] xs, ys, xe, ye;
    logic signed [LINK_BITS-1:0]  link;
    logic [CNTF_BITS-1:0]         cnt;
    logic signed [COORD_BITS-1:0] px, py;
  } request_t;

  typedef struct {
    logic [SECF_BITS-1:0] loc;
    logic                 found;
    logic                 moved;
  } location_t;

  logic clk, rst_n;
  logic in_tvalid, in_tready, out_tvalid, out_tready, cfg_wr_en;
  logic [IN_TDATA_BITS-1:0]  in_tdata;
  logic [0:0]                in_tuser;
  logic [OUT_TDATA_BITS-1:0] out_tdata;
  logic [TOTAL_BITS-1:0]     cfg_wr_data;

  sector_point_locator_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  request_t  pending[$];
  location_t expected_locs[$];
  int errors = 0;
  int cycles = 0;
  logic hold_req = 1'b0;

  // locator state mirror
  longint wall_fx[1024], wall_fy[1024], wall_sx[1024], wall_sy[1024];
  int     wall_nb[1024];
  int     sec_walls[64];
  int     search_total = 0;
  // generation-side record of written wall slots
  bit     gen_written[64][16];
  logic [SECF_BITS-1:0] last_loc = '0;

  function automatic int sgn(longint v);
    return v > 0 ? 1 : (v < 0 ? -1 : 0);
  endfunction

  function automatic bit ray_crosses(longint px, longint py, int w);
    longint ax, ay, bx, by, d, n2;
    int sd, s1, s2;
    ax = px - wall_fx[w];
    ay = py - wall_fy[w];
    bx = wall_sx[w] - wall_fx[w];
    by = wall_sy[w] - wall_fy[w];
    d  = -bx;
    n2 = -ax;
    sd = sgn(d);
    if (sd == 0) return 0;
    s1 = sgn(bx * ay - by * ax);
    s2 = sgn(n2);
    if (s1 != 0 && s1 != sd) return 0;
    if (s2 != 0 && s2 != sd) return 0;
    return sd > 0 ? (n2 <= d) : (n2 >= d);
  endfunction

  function automatic bit in_sector(longint px, longint py, int s);
    int hits;
    hits = 0;
    for (int i = 0; i < sec_walls[s]; i++)
      if (ray_crosses(px, py, s * 16 + i)) hits++;
    return hits[0];
  endfunction

  function automatic void apply_request(request_t r);
    int w, lim, nb;
    location_t res;
    bit hit;
    if (r.cmd == spl_pkg::CMD_LOAD) begin
      w = r.sector * 16 + r.wall;
      wall_fx[w] = r.xs;
      wall_fy[w] = r.ys;
      wall_sx[w] = r.xe;
      wall_sy[w] = r.ye;
      wall_nb[w] = r.link;
      sec_walls[r.sector] = r.cnt > 16 ? 16 : r.cnt;
      return;
    end
    hit = in_sector(r.px, r.py, r.sector);
    res.loc = r.sector;
    for (int i = 0; i < sec_walls[r.sector] && !hit; i++) begin
      nb = wall_nb[r.sector * 16 + i];
      if (nb >= 0 && nb < 64 && in_sector(r.px, r.py, nb)) begin
        hit = 1;
        res.loc = SECF_BITS'(nb);
      end
    end
    lim = search_total > 64 ? 64 : search_total;
    for (int i = 0; i < lim && !hit; i++)
      if (in_sector(r.px, r.py, i)) begin
        hit = 1;
        res.loc = SECF_BITS'(i);
      end
    res.found = hit;
    res.moved = res.loc != r.sector;
    expected_locs.push_back(res);
  endfunction

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > RUN_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // driver
  int burst_left = 4, gap_left = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
      in_tuser  <= '0;
    end else begin
      if (in_tvalid && in_tready) begin
        apply_request(pending[0]);
        void'(pending.pop_front());
      end
      if (!(in_tvalid && !in_tready)) begin
        if (gap_left > 0) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else if (pending.size() > 0) begin
          in_tdata <= {2'b0, pending[0].py, pending[0].px, pending[0].cnt, pending[0].link,
                       pending[0].ye, pending[0].xe, pending[0].ys, pending[0].xs,
                       pending[0].wall, pending[0].sector};
          in_tuser <= pending[0].cmd;
          in_tvalid <= 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver stall pattern
  int rx_mode = 0, rx_left = 0, hold_left = 0;
  bit hold_done = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_done = 1;
      hold_left = LONG_HOLD;
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_mode = $urandom_range(0, 2);
        rx_left = $urandom_range(20, 200);
      end
      rx_left--;
      case (rx_mode)
        0: out_tready <= 1'b1;
        1: out_tready <= 1'($urandom_range(0, 1));
        default: out_tready <= ($urandom_range(0, 4) == 0);
      endcase
    end
  end

  // monitor
  always @(posedge clk) begin
    location_t exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_locs.size() == 0) begin
        $error("result with nothing expected: %h", out_tdata);
        errors++;
      end else begin
        exp_r = expected_locs.pop_front();
        if (out_tdata[5:0] !== exp_r.loc) begin
          $error("located_sector expected %0d got %0d", exp_r.loc, out_tdata[5:0]);
          errors++;
        end
        if (out_tdata[6] !== exp_r.found) begin
          $error("found expected %0d got %0d", exp_r.found, out_tdata[6]);
          errors++;
        end
        if (out_tdata[7] !== exp_r.moved) begin
          $error("moved expected %0d got %0d", exp_r.moved, out_tdata[7]);
          errors++;
        end
      end
    end
  end

  function automatic int written_prefix(int s);
    int n;
    n = 0;
    while (n < 16 && gen_written[s][n]) n++;
    return n;
  endfunction

  task automatic push_load(int s, int w, longint xs, longint ys, longint xe, longint ye,
                           int link, int cnt);
    request_t r;
    r = '{default: '0};
    r.cmd = spl_pkg::CMD_LOAD;
    r.sector = SECF_BITS'(s);
    r.wall = WALLF_BITS'(w);
    r.xs = COORD_BITS'(xs);
    r.ys = COORD_BITS'(ys);
    r.xe = COORD_BITS'(xe);
    r.ye = COORD_BITS'(ye);
    r.link = LINK_BITS'(link);
    r.cnt = CNTF_BITS'(cnt);
    r.px = COORD_BITS'($urandom);
    r.py = COORD_BITS'($urandom);
    gen_written[s][w] = 1;
    pending.push_back(r);
  endtask

  task automatic push_query(int s, longint px, longint py);
    request_t r;
    r = '{default: '0};
    r.cmd = spl_pkg::CMD_LOCATE;
    r.sector = SECF_BITS'(s);
    r.px = COORD_BITS'(px);
    r.py = COORD_BITS'(py);
    r.xs = COORD_BITS'($urandom);
    r.ye = COORD_BITS'($urandom);
    r.link = LINK_BITS'($urandom);
    r.cnt = CNTF_BITS'($urandom);
    pending.push_back(r);
  endtask

  // random wall at most one slot past the written prefix, so no unloaded slot is ever read
  task automatic push_noise_load();
    int s, w, p;
    s = $urandom_range(0, 63);
    p = written_prefix(s);
    w = $urandom_range(0, p > 15 ? 15 : p);
    gen_written[s][w] = 1;
    p = written_prefix(s);
    push_load(s, w, $signed(24'($urandom)), $signed(24'($urandom)), $signed(24'($urandom)),
              $signed(24'($urandom)), $signed(7'($urandom)),
              p == 16 ? $urandom_range(0, 31) : $urandom_range(0, p));
  endtask

  // rectangle cell of the grid, each side split into k collinear walls, counter-clockwise
  task automatic build_cell(int s, int k);
    longint x0, y0, cx[5], cy[5];
    int nbr[4], col, row, w;
    col = s % 8;
    row = s / 8;
    x0 = (col - 4) * CELL;
    y0 = (row - 4) * CELL;
    cx = '{x0, x0 + CELL, x0 + CELL, x0, x0};
    cy = '{y0, y0, y0 + CELL, y0 + CELL, y0};
    nbr[0] = row > 0 ? s - 8 : -1;
    nbr[1] = col < 7 ? s + 1 : -64;
    nbr[2] = row < 7 ? s + 8 : -1;
    nbr[3] = col > 0 ? s - 1 : -1;
    w = 0;
    for (int side = 0; side < 4; side++)
      for (int j = 0; j < k; j++) begin
        push_load(s, w,
                  cx[side] + (cx[side+1] - cx[side]) * j / k,
                  cy[side] + (cy[side+1] - cy[side]) * j / k,
                  cx[side] + (cx[side+1] - cx[side]) * (j + 1) / k,
                  cy[side] + (cy[side+1] - cy[side]) * (j + 1) / k,
                  ($urandom_range(0, 4) == 0) ? -1 : nbr[side], w + 1);
        w++;
      end
    if (k == 4)
      push_load(s, 15, cx[4] - CELL / 4, cy[4], cx[4], cy[4], nbr[3], $urandom_range(17, 31));
  endtask

  task automatic push_grid_query();
    longint px, py;
    int s;
    if ($urandom_range(0, 4) == 0) begin
      px = $signed(24'($urandom));
      py = $signed(24'($urandom));
    end else begin
      px = $urandom_range(0, 10 * CELL) - 5 * CELL;
      py = $urandom_range(0, 10 * CELL) - 5 * CELL;
      if ($urandom_range(0, 2) == 0) begin
        px = px - (px % (CELL / 4));
        py = py - (py % (CELL / 4));
      end
    end
    s = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63) : last_loc;
    push_query(s, px, py);
  endtask

  task automatic settle();
    while (pending.size() > 0 || expected_locs.size() > 0 || in_tvalid) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic write_total(int v);
    settle();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= TOTAL_BITS'(v);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    search_total = v;
    @(posedge clk);
  endtask

  // keeps the entity's current sector following the located one
  always @(posedge clk)
    if (rst_n && out_tvalid && out_tready) last_loc <= out_tdata[5:0];

  initial begin
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty table, extremes, parallel walls, solid links
    write_total(0);
    push_query(0, 0, 0);
    push_query(63, -8388608, 8388607);
    push_load(63, 0, -8388608, -8388608, 8388607, -8388608, -1, 1);
    push_load(63, 1, 8388607, -8388608, 8388607, 8388607, -64, 2);
    push_load(63, 2, 8388607, 8388607, -8388608, 8388607, 63, 3);
    push_load(63, 3, -8388608, 8388607, -8388608, -8388608, 0, 4);
    push_query(63, 0, 0);
    push_query(63, -8388608, -8388608);
    push_query(63, 8388607, 8388607);
    push_query(0, 100, -100);
    push_load(5, 0, 256, 0, 256, 512, -1, 1);
    push_query(5, 0, -256);
    push_query(5, 256, 0);
    push_load(5, 1, 0, 0, 512, 0, 63, 2);
    push_query(5, 256, -256);
    push_query(0, 0, 0);
    write_total(127);
    push_query(0, 0, 0);
    push_query(0, -8388608, 8388607);
    write_total(64);

    // grid map with neighbour links
    for (int s = 0; s < 24; s++)
      build_cell(s, ($urandom_range(0, 5) == 0) ? 4 : $urandom_range(1, 2));
    for (int i = 0; i < 120; i++) push_grid_query();
    settle();

    // sender paused until every result came; then receiver holds off for a long stretch
    write_total(127);
    for (int i = 0; i < 40; i++) push_grid_query();
    hold_req <= 1'b1;
    for (int i = 0; i < 80; i++)
      if ($urandom_range(0, 7) == 0) push_noise_load();
      else push_grid_query();

    write_total($urandom_range(1, 63));
    for (int i = 0; i < 70; i++)
      if ($urandom_range(0, 9) == 0) push_noise_load();
      else push_grid_query();

    settle();
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
